// File: hw/rtl/lru_rca_pkg.sv
`default_nettype none

package lru_rca_pkg;

    // Pool and field sizes.
    localparam int POOL_SIZE   = 10;
    localparam int GUEST_COUNT = 34;
    localparam int SLOT_W      = $clog2(POOL_SIZE + 1);
    localparam int GUEST_W     = 6;
    localparam int NODE_W      = 8;
    localparam int HOST_W      = 5;
    localparam int KIND_W      = 3;
    localparam int REQ_W       = 3;
    localparam int CNT_W       = 2;
    localparam int CFG_W       = 4;

    // Request types.
    localparam logic [REQ_W-1:0] REQ_BEGIN   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WRITE   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_MODIFY  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SCRATCH = 3'd4;
    localparam logic [REQ_W-1:0] REQ_FLUSH   = 3'd5;

    // Result kinds.
    localparam logic [KIND_W-1:0] K_ASSIGNED  = 3'd0;
    localparam logic [KIND_W-1:0] K_NOREG     = 3'd1;
    localparam logic [KIND_W-1:0] K_PRELOAD   = 3'd2;
    localparam logic [KIND_W-1:0] K_LOAD      = 3'd3;
    localparam logic [KIND_W-1:0] K_WRITEBACK = 3'd4;
    localparam logic [KIND_W-1:0] K_DONE      = 3'd5;

    // Source of the at_node field of a result.
    localparam logic [1:0] AT_NODE = 2'd0;
    localparam logic [1:0] AT_CAP  = 2'd1;
    localparam logic [1:0] AT_FILL = 2'd2;

    // Source of the guest_num field of a result.
    localparam logic [1:0] GSEL_REQ   = 2'd0;
    localparam logic [1:0] GSEL_OWNER = 2'd1;
    localparam logic [1:0] GSEL_ZERO  = 2'd2;

    // Source of the current slot pointer.
    localparam logic [1:0] CUR_HIT  = 2'd0;
    localparam logic [1:0] CUR_LRU  = 2'd1;
    localparam logic [1:0] CUR_SCAN = 2'd2;
    localparam logic [1:0] CUR_ZERO = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              latch;
        logic              clear_all;
        logic              flush_clear;
        logic              set_cur;
        logic [1:0]        cur_sel;
        logic              cur_inc;
        logic              scan_reset;
        logic              rank_inc;
        logic              got_inc;
        logic              evict_cur;
        logic              fill_cur;
        logic              count_preload;
        logic              touch_cur;
        logic              mark_used;
        logic              emit;
        logic [KIND_W-1:0] emit_kind;
        logic [1:0]        at_sel;
        logic [1:0]        guest_sel;
        logic              host_cur;
        logic              last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             bad_guest;
        logic             hit;
        logic             cur_fd;
        logic             scan_fd;
        logic             scan_masked;
        logic             scan_end;
        logic             got_done;
        logic             walk_end;
        logic             emit_ok;
    } status_t;

endpackage

`default_nettype wire

// File: hw/rtl/lru_rca_dp.sv
`default_nettype none

module lru_rca_dp
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [lru_rca_pkg::CFG_W-1:0]   cfg_wdata,
    input  wire logic [lru_rca_pkg::REQ_W-1:0]   in_req_type,
    input  wire logic [lru_rca_pkg::GUEST_W-1:0] in_guest,
    input  wire logic [lru_rca_pkg::NODE_W-1:0]  in_node,
    input  wire logic [lru_rca_pkg::CNT_W-1:0]   in_cnt,
    input  wire logic [lru_rca_pkg::POOL_SIZE-1:0] in_mask,
    input  wire lru_rca_pkg::cmd_t               cmd,
    output lru_rca_pkg::status_t                 status,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic [lru_rca_pkg::KIND_W-1:0]       out_kind,
    output logic [lru_rca_pkg::NODE_W-1:0]       out_at,
    output logic [lru_rca_pkg::GUEST_W-1:0]      out_guest,
    output logic [lru_rca_pkg::HOST_W-1:0]       out_host,
    output logic                                 out_last
);

    localparam int P      = lru_rca_pkg::POOL_SIZE;
    localparam int SW     = lru_rca_pkg::SLOT_W;
    localparam int HOST_W = lru_rca_pkg::HOST_W;

    // Latched request.
    logic [lru_rca_pkg::REQ_W-1:0]   req_type_reg;
    logic [lru_rca_pkg::GUEST_W-1:0] req_guest_reg;
    logic [lru_rca_pkg::NODE_W-1:0]  req_node_reg;
    logic [lru_rca_pkg::CNT_W-1:0]   req_cnt_reg;
    logic [P-1:0]                    req_mask_reg;

    // Per-slot state.
    logic [lru_rca_pkg::GUEST_W-1:0] owner_reg [P];
    logic [P-1:0]                    full_reg;
    logic [P-1:0]                    dirty_reg;
    logic [P-1:0]                    used_reg;
    logic [P-1:0]                    lw_reg;
    logic [lru_rca_pkg::NODE_W-1:0]  last_node_reg [P];
    logic [SW-1:0]                   rank_reg [P];
    logic [SW-1:0]                   preload_cnt_reg;

    // Walk pointers and configuration.
    logic [SW-1:0]                   cur_reg;
    logic [SW-1:0]                   scan_rank_reg;
    logic [lru_rca_pkg::CNT_W-1:0]   got_reg;
    logic [lru_rca_pkg::CFG_W-1:0]   first_host_reg;

    // Output register.
    logic                            out_valid_reg;
    logic [lru_rca_pkg::KIND_W-1:0]  out_kind_reg;
    logic [lru_rca_pkg::NODE_W-1:0]  out_at_reg;
    logic [lru_rca_pkg::GUEST_W-1:0] out_guest_reg;
    logic [lru_rca_pkg::HOST_W-1:0]  out_host_reg;
    logic                            out_last_reg;

    logic [SW-1:0]                   hit_slot;
    logic                            hit_any;
    logic [SW-1:0]                   lru_slot;
    logic [SW-1:0]                   scan_slot;
    logic                            cur_valid;
    logic [SW-1:0]                   cur_rank;
    logic [lru_rca_pkg::NODE_W:0]    cap_sum;
    logic [lru_rca_pkg::NODE_W-1:0]  cap_at;
    logic                            preload_ok;
    logic                            emit_ok;
    logic                            is_read;
    logic [SW-1:0]                   cur_next;
    logic [lru_rca_pkg::KIND_W-1:0]  kind_next;
    logic [lru_rca_pkg::NODE_W-1:0]  at_next;
    logic [lru_rca_pkg::GUEST_W-1:0] guest_next;
    logic [lru_rca_pkg::HOST_W-1:0]  host_next;

    // Parallel slot lookups: owner match, least recent slot and slot at the scan rank.
    always_comb
    begin
        hit_slot  = '0;
        hit_any   = 1'b0;
        lru_slot  = '0;
        scan_slot = '0;
        for (int s = 0; s < P; s++)
        begin
            if (full_reg[s] && owner_reg[s] == req_guest_reg)
            begin
                hit_slot = SW'(s);
                hit_any  = 1'b1;
            end
            if (rank_reg[s] == '0)
            begin
                lru_slot = SW'(s);
            end
            if (rank_reg[s] == scan_rank_reg)
            begin
                scan_slot = SW'(s);
            end
        end
    end

    // Current slot fields and the capped writeback node.
    always_comb
    begin
        cur_valid  = cur_reg < SW'(P);
        cur_rank   = cur_valid ? rank_reg[cur_reg] : '0;
        cap_sum    = cur_valid ? ({1'b0, last_node_reg[cur_reg]} + {8'd0, lw_reg[cur_reg]})
                               : '0;
        cap_at     = (cap_sum > {1'b0, req_node_reg}) ? req_node_reg : cap_sum[7:0];
        preload_ok = cur_valid && !used_reg[cur_reg] && (preload_cnt_reg < SW'(P));
        emit_ok    = !out_valid_reg || out_ready;
        is_read    = req_type_reg == lru_rca_pkg::REQ_READ;
    end

    // Status towards the controller.
    always_comb
    begin
        status.req_type    = req_type_reg;
        status.bad_guest   = (req_guest_reg == '0)
                             || (32'(req_guest_reg) >= 32'(lru_rca_pkg::GUEST_COUNT));
        status.hit         = hit_any;
        status.cur_fd      = cur_valid && full_reg[cur_reg] && dirty_reg[cur_reg];
        status.scan_fd     = full_reg[scan_slot] && dirty_reg[scan_slot];
        status.scan_masked = req_mask_reg[scan_slot];
        status.scan_end    = scan_rank_reg == SW'(P);
        status.got_done    = got_reg == req_cnt_reg;
        status.walk_end    = cur_reg == SW'(P);
        status.emit_ok     = emit_ok;
    end

    // Next slot pointer.
    always_comb
    begin
        cur_next = cur_reg;
        if (cmd.set_cur)
        begin
            case (cmd.cur_sel)
                lru_rca_pkg::CUR_HIT:  cur_next = hit_slot;
                lru_rca_pkg::CUR_LRU:  cur_next = lru_slot;
                lru_rca_pkg::CUR_SCAN: cur_next = scan_slot;
                default:               cur_next = '0;
            endcase
        end
        else if (cmd.cur_inc)
        begin
            cur_next = cur_reg + 1'b1;
        end
    end

    // Result field selection.
    always_comb
    begin
        kind_next = cmd.emit_kind;
        at_next   = req_node_reg;
        case (cmd.at_sel)
            lru_rca_pkg::AT_CAP:  at_next = cap_at;
            lru_rca_pkg::AT_FILL:
            begin
                kind_next = preload_ok ? lru_rca_pkg::K_PRELOAD : lru_rca_pkg::K_LOAD;
                at_next   = preload_ok ? '0 : req_node_reg;
            end
            default:              at_next = req_node_reg;
        endcase
        case (cmd.guest_sel)
            lru_rca_pkg::GSEL_REQ:   guest_next = req_guest_reg;
            lru_rca_pkg::GSEL_OWNER: guest_next = cur_valid ? owner_reg[cur_reg] : '0;
            default:                 guest_next = '0;
        endcase
        host_next = cmd.host_cur ? (HOST_W'(first_host_reg) + HOST_W'(cur_reg)) : '0;
    end

    // Request latch; payload only.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_type_reg  <= in_req_type;
            req_guest_reg <= in_guest;
            req_node_reg  <= in_node;
            req_cnt_reg   <= in_cnt;
            req_mask_reg  <= in_mask;
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_host_reg <= 4'd3;
        end
        else if (cfg_we)
        begin
            first_host_reg <= cfg_wdata;
        end
    end

    // Pointers and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            scan_rank_reg <= '0;
            got_reg       <= '0;
        end
        else
        begin
            cur_reg <= cur_next;
            if (cmd.scan_reset)
            begin
                scan_rank_reg <= '0;
                got_reg       <= '0;
            end
            else
            begin
                if (cmd.rank_inc)
                begin
                    scan_rank_reg <= scan_rank_reg + 1'b1;
                end
                if (cmd.got_inc)
                begin
                    got_reg <= got_reg + 1'b1;
                end
            end
        end
    end

    // Slot state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg        <= '0;
            dirty_reg       <= '0;
            used_reg        <= '0;
            lw_reg          <= '0;
            preload_cnt_reg <= '0;
            for (int s = 0; s < P; s++)
            begin
                owner_reg[s]     <= '0;
                last_node_reg[s] <= '0;
                rank_reg[s]      <= SW'(s);
            end
        end
        else if (cmd.clear_all)
        begin
            full_reg        <= '0;
            dirty_reg       <= '0;
            used_reg        <= '0;
            lw_reg          <= '0;
            preload_cnt_reg <= '0;
            for (int s = 0; s < P; s++)
            begin
                last_node_reg[s] <= '0;
                rank_reg[s]      <= SW'(s);
            end
        end
        else if (cmd.flush_clear)
        begin
            full_reg  <= '0;
            dirty_reg <= '0;
            lw_reg    <= '0;
            for (int s = 0; s < P; s++)
            begin
                last_node_reg[s] <= req_node_reg;
            end
        end
        else
        begin
            if (cmd.fill_cur && cmd.count_preload && preload_ok)
            begin
                preload_cnt_reg <= preload_cnt_reg + 1'b1;
            end
            for (int s = 0; s < P; s++)
            begin
                if (SW'(s) == cur_reg)
                begin
                    if (cmd.evict_cur)
                    begin
                        full_reg[s]  <= 1'b0;
                        dirty_reg[s] <= 1'b0;
                    end
                    if (cmd.fill_cur)
                    begin
                        owner_reg[s] <= req_guest_reg;
                        full_reg[s]  <= 1'b1;
                        used_reg[s]  <= 1'b1;
                    end
                    if (cmd.mark_used)
                    begin
                        used_reg[s] <= 1'b1;
                    end
                    if (cmd.touch_cur)
                    begin
                        last_node_reg[s] <= req_node_reg;
                        lw_reg[s]        <= !is_read;
                        if (!is_read)
                        begin
                            dirty_reg[s] <= 1'b1;
                        end
                    end
                end
                // The touched slot becomes most recent; those above it move down.
                if (cmd.touch_cur)
                begin
                    if (rank_reg[s] == cur_rank)
                    begin
                        rank_reg[s] <= SW'(P - 1);
                    end
                    else if (rank_reg[s] > cur_rank)
                    begin
                        rank_reg[s] <= rank_reg[s] - 1'b1;
                    end
                end
            end
        end
    end

    // Output register: a result waits here while the next is prepared.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg  <= kind_next;
            out_at_reg    <= at_next;
            out_guest_reg <= guest_next;
            out_host_reg  <= host_next;
            out_last_reg  <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_at    = out_at_reg;
    assign out_guest = out_guest_reg;
    assign out_host  = out_host_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// File: hw/rtl/lru_rca_ctrl.sv
`default_nettype none

module lru_rca_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire lru_rca_pkg::status_t  status,
    output lru_rca_pkg::cmd_t          cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_DECODE    = 4'd1;
    localparam logic [3:0] ST_RW_EVICT  = 4'd2;
    localparam logic [3:0] ST_RW_FILL   = 4'd3;
    localparam logic [3:0] ST_RW_ASSIGN = 4'd4;
    localparam logic [3:0] ST_SC_SCAN   = 4'd5;
    localparam logic [3:0] ST_SC_WB     = 4'd6;
    localparam logic [3:0] ST_SC_ASSIGN = 4'd7;
    localparam logic [3:0] ST_FL_WALK   = 4'd8;
    localparam logic [3:0] ST_DONE      = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       is_rw;

    assign is_rw = status.req_type == lru_rca_pkg::REQ_READ
                   || status.req_type == lru_rca_pkg::REQ_WRITE
                   || status.req_type == lru_rca_pkg::REQ_MODIFY;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencing of each request; a result is issued only when the output register is free.
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.emit_kind = lru_rca_pkg::K_DONE;
        cmd.at_sel    = lru_rca_pkg::AT_NODE;
        cmd.guest_sel = lru_rca_pkg::GSEL_ZERO;
        cmd.cur_sel   = lru_rca_pkg::CUR_ZERO;
        in_ready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (is_rw)
                begin
                    if (status.bad_guest)
                    begin
                        cmd.emit_kind = lru_rca_pkg::K_NOREG;
                        cmd.guest_sel = lru_rca_pkg::GSEL_REQ;
                        cmd.last      = 1'b1;
                        if (status.emit_ok)
                        begin
                            cmd.emit   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else if (status.hit)
                    begin
                        cmd.set_cur = 1'b1;
                        cmd.cur_sel = lru_rca_pkg::CUR_HIT;
                        state_next  = ST_RW_ASSIGN;
                    end
                    else
                    begin
                        cmd.set_cur = 1'b1;
                        cmd.cur_sel = lru_rca_pkg::CUR_LRU;
                        state_next  = ST_RW_EVICT;
                    end
                end
                else if (status.req_type == lru_rca_pkg::REQ_BEGIN)
                begin
                    cmd.clear_all = 1'b1;
                    state_next    = ST_DONE;
                end
                else if (status.req_type == lru_rca_pkg::REQ_SCRATCH)
                begin
                    cmd.scan_reset = 1'b1;
                    state_next     = ST_SC_SCAN;
                end
                else if (status.req_type == lru_rca_pkg::REQ_FLUSH)
                begin
                    cmd.set_cur = 1'b1;
                    state_next  = ST_FL_WALK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RW_EVICT:
            begin
                cmd.emit_kind = lru_rca_pkg::K_WRITEBACK;
                cmd.at_sel    = lru_rca_pkg::AT_CAP;
                cmd.guest_sel = lru_rca_pkg::GSEL_OWNER;
                cmd.host_cur  = 1'b1;
                if (!status.cur_fd || status.emit_ok)
                begin
                    cmd.emit      = status.cur_fd;
                    cmd.evict_cur = 1'b1;
                    state_next    = ST_RW_FILL;
                end
            end
            ST_RW_FILL:
            begin
                cmd.at_sel        = lru_rca_pkg::AT_FILL;
                cmd.guest_sel     = lru_rca_pkg::GSEL_REQ;
                cmd.host_cur      = 1'b1;
                cmd.count_preload = 1'b1;
                if (status.req_type == lru_rca_pkg::REQ_WRITE)
                begin
                    cmd.count_preload = 1'b0;
                    cmd.fill_cur      = 1'b1;
                    state_next        = ST_RW_ASSIGN;
                end
                else if (status.emit_ok)
                begin
                    cmd.emit     = 1'b1;
                    cmd.fill_cur = 1'b1;
                    state_next   = ST_RW_ASSIGN;
                end
            end
            ST_RW_ASSIGN:
            begin
                cmd.emit_kind = lru_rca_pkg::K_ASSIGNED;
                cmd.guest_sel = lru_rca_pkg::GSEL_REQ;
                cmd.host_cur  = 1'b1;
                cmd.last      = 1'b1;
                if (status.emit_ok)
                begin
                    cmd.emit      = 1'b1;
                    cmd.touch_cur = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SC_SCAN:
            begin
                if (status.scan_end || status.got_done)
                begin
                    state_next = ST_DONE;
                end
                else if (status.scan_masked)
                begin
                    cmd.rank_inc = 1'b1;
                end
                else
                begin
                    cmd.set_cur = 1'b1;
                    cmd.cur_sel = lru_rca_pkg::CUR_SCAN;
                    state_next  = status.scan_fd ? ST_SC_WB : ST_SC_ASSIGN;
                end
            end
            ST_SC_WB:
            begin
                cmd.emit_kind = lru_rca_pkg::K_WRITEBACK;
                cmd.at_sel    = lru_rca_pkg::AT_CAP;
                cmd.guest_sel = lru_rca_pkg::GSEL_OWNER;
                cmd.host_cur  = 1'b1;
                if (status.emit_ok)
                begin
                    cmd.emit      = 1'b1;
                    cmd.evict_cur = 1'b1;
                    state_next    = ST_SC_ASSIGN;
                end
            end
            ST_SC_ASSIGN:
            begin
                cmd.emit_kind = lru_rca_pkg::K_ASSIGNED;
                cmd.host_cur  = 1'b1;
                if (status.emit_ok)
                begin
                    cmd.emit      = 1'b1;
                    cmd.evict_cur = 1'b1;
                    cmd.mark_used = 1'b1;
                    cmd.got_inc   = 1'b1;
                    cmd.rank_inc  = 1'b1;
                    state_next    = ST_SC_SCAN;
                end
            end
            ST_FL_WALK:
            begin
                cmd.emit_kind = lru_rca_pkg::K_WRITEBACK;
                cmd.guest_sel = lru_rca_pkg::GSEL_OWNER;
                cmd.host_cur  = 1'b1;
                if (status.walk_end)
                begin
                    cmd.flush_clear = 1'b1;
                    state_next      = ST_DONE;
                end
                else if (!status.cur_fd)
                begin
                    cmd.cur_inc = 1'b1;
                end
                else if (status.emit_ok)
                begin
                    cmd.emit    = 1'b1;
                    cmd.cur_inc = 1'b1;
                end
            end
            ST_DONE:
            begin
                cmd.last = 1'b1;
                if (status.emit_ok)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/lru_register_cache_allocator.sv
`default_nettype none

// Write-back LRU allocator of ten host registers for guest registers. One request
// is handled at a time: s_tready is high only while the block is idle. A read, write
// or modify request gets no register for a bad guest, hits, or misses and takes
// the least recent slot, writing it back first if dirty; flush walks all ten slots
// one per cycle while the output register can take each writeback, issuing each
// writeback in the cycle of its slot; a scratch request passes over barred slots
// and hands out slots, with a writeback for each dirty one it hands out. Each
// result waits in a single output register, so m_tready holding a result back
// stalls the request. Write first_host_reg only while idle.
module lru_register_cache_allocator
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_wdata,  // first_host_reg
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,    // guest_reg[5:0], node_index[13:6],
                                         // scratch_count[15:14], exclude_mask[25:16]
    input  wire logic [2:0]  s_tuser,    // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,    // at_node[7:0], guest_num[13:8], host_reg[18:14]
    output logic [2:0]       m_tuser,    // kind
    output logic             m_tlast     // last_item
);

    lru_rca_pkg::cmd_t    cmd;
    lru_rca_pkg::status_t status;
    logic [7:0]           out_at;
    logic [5:0]           out_guest;
    logic [4:0]           out_host;

    lru_rca_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lru_rca_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_req_type (s_tuser),
        .in_guest    (s_tdata[5:0]),
        .in_node     (s_tdata[13:6]),
        .in_cnt      (s_tdata[15:14]),
        .in_mask     (s_tdata[25:16]),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_kind    (m_tuser),
        .out_at      (out_at),
        .out_guest   (out_guest),
        .out_host    (out_host),
        .out_last    (m_tlast)
    );

    // Pack the result fields, lowest first.
    assign m_tdata = {5'd0, out_host, out_guest, out_at};

endmodule

`default_nettype wire
